/* hdl/rsw_pkg.sv */
`default_nettype none
package rsw_pkg;

  localparam int ADDR_W = 48;
  localparam int DEF_NUM_PARTITIONS = 256;
  localparam int DEF_LINE_BYTES = 64;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 3;

  localparam logic [1:0] CMD_SEED   = 2'd0;
  localparam logic [1:0] CMD_ROW    = 2'd1;
  localparam logic [1:0] CMD_DRAIN  = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ELEM_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WC        = 1'd1;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [7:0]        partition;
    logic [ADDR_W-1:0] address;
    logic [63:0]       data_low;
    logic [63:0]       data_high;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] write_address;
    logic [63:0]       write_data;
    logic [7:0]        byte_enable;
    logic              last_beat;
  } out_item_t;

endpackage
`default_nettype wire

/* hdl/radix_scatter_write_combine.sv */
// Seed: cursor and fill are written, no beat. Row or drain: cursor and fill are
// fetched, then direct rows give one beat per cycle (1 to 3 beats) unless out_ready
// stalls; staged rows write the line store, and a flush reads it before each beat.
// One item is in work at a time; in_ready is high only between items.
// Reset (rst_n low, synchronous) clears control and config; cursors, fill levels
// and line contents are undefined until a partition is seeded.
`default_nettype none
module radix_scatter_write_combine #(
  parameter int NUM_PARTITIONS = rsw_pkg::DEF_NUM_PARTITIONS,
  parameter int LINE_BYTES_PARAM = rsw_pkg::DEF_LINE_BYTES
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire rsw_pkg::in_item_t                  in_item,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output rsw_pkg::out_item_t                      out_item,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [rsw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [rsw_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import rsw_pkg::*;

  localparam int PW  = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
  localparam int LBB = $clog2(LINE_BYTES_PARAM);
  localparam int FB  = LBB + 1;
  localparam int NW  = LINE_BYTES_PARAM / 8;
  localparam int WB  = LBB - 3;
  localparam int MW  = ADDR_W + FB;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_META   = 3'd1;
  localparam logic [2:0] S_DIRECT = 3'd2;
  localparam logic [2:0] S_STAGE  = 3'd3;
  localparam logic [2:0] S_FRD    = 3'd4;
  localparam logic [2:0] S_FOUT   = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [2:0] esz_r;
  logic       wc_r;

  in_item_t   item_r;
  logic [PW-1:0] p_r;
  logic [1:0]    dk_r;
  logic [1:0]    dlast_r;
  logic [2:0][63:0] win_r;
  logic [2:0][7:0]  winm_r;
  logic [WB-1:0]    fw_r;
  logic             flush_r;
  logic [WB-1:0]    fk_r;
  logic [WB-1:0]    fhi_r;
  logic [FB-1:0]    flo_r;
  logic [FB-1:0]    fend_r;
  logic [ADDR_W-1:0] base_r;
  logic [ADDR_W-1:0] dcur_r;
  logic              out_valid_r;
  out_item_t         out_item_r;

  logic [PW-1:0] in_p;
  logic          in_ok;
  logic          acc;
  logic          meta_rd_en;
  logic [MW-1:0] meta_rd;
  logic          meta_wr_en;
  logic [PW-1:0] meta_wr_addr;
  logic [MW-1:0] meta_wr_data;
  logic [ADDR_W-1:0] cur;
  logic [FB-1:0] fill, m, fsum;
  logic [4:0]    w;
  logic [2:0]    lg;
  logic [2:0]    o;
  logic [15:0]   emask;
  logic [127:0]  edata;
  logic [191:0]  sh;
  logic [23:0]   shm;
  logic          full;
  logic [WB+1:0] wa;
  logic [7:0]    stage_be;
  logic          line_rd_en;
  logic [63:0]   line_rd;
  logic          can_load;
  logic [7:0]    fmask;
  logic [63:0]   fdata;

  assign in_p  = PW'(in_item.partition);
  assign in_ok = (32'(in_item.partition) < NUM_PARTITIONS) && (in_item.cmd != CMD_UNUSED);
  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign acc = in_valid && in_ready;
  assign can_load = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign meta_rd_en = acc && in_ok && (in_item.cmd != CMD_SEED);

  assign cur  = meta_rd[MW-1:FB];
  assign fill = meta_rd[FB-1:0];
  assign m    = FB'(cur[LBB-1:0]);
  assign lg   = (esz_r > 3'd4) ? 3'd4 : esz_r;
  assign w    = 5'(6'd1 << lg);
  assign fsum = fill + FB'(w);
  assign full = fsum >= FB'(LINE_BYTES_PARAM);
  assign o    = wc_r ? fill[2:0] : cur[2:0];
  assign emask = 16'((17'd1 << w) - 17'd1);

  always_comb begin
    for (int b = 0; b < 16; b++) begin
      edata[8*b +: 8] = emask[b] ? {item_r.data_high, item_r.data_low}[8*b +: 8] : 8'd0;
    end
  end

  assign sh   = {64'd0, edata} << {o, 3'b000};
  assign shm  = {8'd0, emask} << o;

  always_comb begin
    meta_wr_en   = 1'b0;
    meta_wr_addr = in_p;
    meta_wr_data = {in_item.address, FB'(in_item.address[LBB-1:0])};
    if (state_r == S_IDLE) begin
      meta_wr_en = acc && in_ok && (in_item.cmd == CMD_SEED);
    end else if (state_r == S_META) begin
      meta_wr_addr = p_r;
      if (item_r.cmd == CMD_ROW) begin
        meta_wr_en = 1'b1;
        if (!wc_r) begin
          meta_wr_data = {cur + ADDR_W'(w), fill};
        end else if (full) begin
          meta_wr_data = {cur + ADDR_W'(FB'(LINE_BYTES_PARAM) - m), FB'(0)};
        end else begin
          meta_wr_data = {cur, fsum};
        end
      end else begin
        meta_wr_en   = wc_r && (fill > m);
        meta_wr_data = {cur + ADDR_W'(fill - m), fill};
      end
    end
  end

  assign wa       = (WB+2)'(fw_r) + (WB+2)'(dk_r);
  assign stage_be = ((state_r == S_STAGE) && (wa < (WB+2)'(NW))) ? winm_r[dk_r] : 8'd0;
  assign line_rd_en = (state_r == S_FRD);

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      fmask[b] = ({1'b0, fk_r, 3'(b)} >= flo_r) && ({1'b0, fk_r, 3'(b)} < fend_r);
      fdata[8*b +: 8] = fmask[b] ? line_rd[8*b +: 8] : 8'd0;
    end
  end

  rsw_meta_ram #(.DEPTH(NUM_PARTITIONS), .WIDTH(MW)) u_meta (
    .clk     (clk),
    .rd_en   (meta_rd_en),
    .rd_addr (in_p),
    .rd_data (meta_rd),
    .wr_en   (meta_wr_en),
    .wr_addr (meta_wr_addr),
    .wr_data (meta_wr_data)
  );

  rsw_line_ram #(.DEPTH(NUM_PARTITIONS * NW)) u_line (
    .clk     (clk),
    .rd_en   (line_rd_en),
    .rd_addr ({p_r, fk_r}),
    .rd_data (line_rd),
    .wr_be   (stage_be),
    .wr_addr ({p_r, wa[WB-1:0]}),
    .wr_data (win_r[dk_r])
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (meta_rd_en) begin
          state_nxt = S_META;
        end
      end
      S_META: begin
        if (item_r.cmd == CMD_ROW) begin
          state_nxt = wc_r ? S_STAGE : S_DIRECT;
        end else if (wc_r && (fill > m)) begin
          state_nxt = S_FRD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DIRECT: begin
        if (can_load && (dk_r == dlast_r)) begin
          state_nxt = S_IDLE;
        end
      end
      S_STAGE: begin
        if (dk_r == 2'd2) begin
          state_nxt = flush_r ? S_FRD : S_IDLE;
        end
      end
      S_FRD: state_nxt = S_FOUT;
      S_FOUT: begin
        if (can_load) begin
          state_nxt = (fk_r == fhi_r) ? S_IDLE : S_FRD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      esz_r       <= 3'd3;
      wc_r        <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ELEM_SIZE: esz_r <= cfg_data;
          CFG_WC:        wc_r  <= cfg_data[0];
          default: ;
        endcase
      end
      if (((state_r == S_DIRECT) || (state_r == S_FOUT)) && can_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      item_r <= in_item;
      p_r    <= in_p;
    end
    case (state_r)
      S_META: begin
        dk_r    <= 2'd0;
        win_r   <= sh;
        winm_r  <= shm;
        dlast_r <= (shm[23:16] != 8'd0) ? 2'd2 : ((shm[15:8] != 8'd0) ? 2'd1 : 2'd0);
        fw_r    <= fill[LBB-1:3];
        flush_r <= full;
        fk_r    <= m[LBB-1:3];
        flo_r   <= m;
        base_r  <= cur - ADDR_W'(m);
        dcur_r  <= {cur[ADDR_W-1:3], 3'b000};
        if (item_r.cmd == CMD_ROW) begin
          fhi_r  <= WB'(NW - 1);
          fend_r <= FB'(LINE_BYTES_PARAM);
        end else begin
          fhi_r  <= WB'((fill - FB'(1)) >> 3);
          fend_r <= fill;
        end
      end
      S_DIRECT: begin
        if (can_load) begin
          dk_r <= dk_r + 2'd1;
          out_item_r.write_address <= dcur_r + ADDR_W'({dk_r, 3'b000});
          out_item_r.write_data    <= win_r[dk_r];
          out_item_r.byte_enable   <= winm_r[dk_r];
          out_item_r.last_beat     <= (dk_r == dlast_r);
        end
      end
      S_STAGE: dk_r <= dk_r + 2'd1;
      S_FOUT: begin
        if (can_load) begin
          fk_r <= fk_r + WB'(1);
          out_item_r.write_address <= base_r + ADDR_W'({fk_r, 3'b000});
          out_item_r.write_data    <= fdata;
          out_item_r.byte_enable   <= fmask;
          out_item_r.last_beat     <= (fk_r == fhi_r);
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

/* hdl/rsw_meta_ram.sv */
`default_nettype none
module rsw_meta_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 55
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

/* hdl/rsw_line_ram.sv */
`default_nettype none
module rsw_line_ram #(
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [63:0]              rd_data,
  input  wire logic [7:0]               wr_be,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [63:0]              wr_data
);
  logic [63:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    for (int b = 0; b < 8; b++) begin
      if (wr_be[b]) begin
        mem[wr_addr][8*b +: 8] <= wr_data[8*b +: 8];
      end
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

/* hdl/rsw_checker.sv */
`default_nettype none
module rsw_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_ready,
  input wire rsw_pkg::in_item_t              in_item,
  input wire logic                           out_valid,
  input wire logic                           out_ready,
  input wire rsw_pkg::out_item_t             out_item,
  input wire logic                           cfg_valid,
  input wire logic                           cfg_ready,
  input wire logic [rsw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input wire logic [rsw_pkg::CFG_DATA_W-1:0] cfg_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled item changed");

  a_be_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.byte_enable != 8'd0)
    else $error("beat without enabled lanes");

  a_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.write_address[2:0] == 3'd0)
    else $error("unaligned beat address");

  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready && !in_ready |=> !(in_valid && in_ready) || out_valid)
    else $error("accept while beat lost");
endmodule

bind radix_scatter_write_combine rsw_checker u_rsw_checker (.*);
`default_nettype wire

/* tb/sv/rsw_checker.sv */
`default_nettype none
module rsw_scoreboard (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  input  wire logic                           in_ready,
  input  wire rsw_pkg::in_item_t              in_item,
  input  wire logic                           out_valid,
  input  wire logic                           out_ready,
  input  wire rsw_pkg::out_item_t             out_item,
  input  wire logic                           cfg_valid,
  input  wire logic                           cfg_ready,
  input  wire logic [rsw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rsw_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                                  fail_count,
  output int                                  pending,
  output int                                  beats_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import rsw_pkg::*;

  localparam int LINE = DEF_LINE_BYTES;

  logic [2:0]        size_code;
  logic              combining;
  logic [ADDR_W-1:0] cursor [DEF_NUM_PARTITIONS];
  logic [6:0]        fill [DEF_NUM_PARTITIONS];
  logic [7:0]        line_store [DEF_NUM_PARTITIONS][LINE];
  out_item_t         beat_q [$];

  task automatic queue_beats(input logic [ADDR_W-1:0] addr, input logic [7:0] bytes [LINE],
                             input int len);
    out_item_t         beat;
    logic [ADDR_W-1:0] a;
    beat = '0;
    for (int i = 0; i < len; i++) begin
      a = addr + ADDR_W'(i);
      if (i == 0 || a[ADDR_W-1:3] != beat.write_address[ADDR_W-1:3]) begin
        if (i != 0) beat_q = {beat_q, beat};
        beat = '0;
        beat.write_address = {a[ADDR_W-1:3], 3'b000};
      end
      beat.write_data[8*a[2:0] +: 8] = bytes[i];
      beat.byte_enable[a[2:0]] = 1'b1;
    end
    beat.last_beat = 1'b1;
    beat_q = {beat_q, beat};
  endtask

  task automatic predict_beats(input in_item_t it);
    int                width;
    int                lvl;
    int                ofs;
    int                p;
    logic [ADDR_W-1:0] cur;
    logic [7:0]        bytes [LINE];
    p     = it.partition;
    width = 1 << ((size_code > 3'd4) ? 4 : size_code);
    cur   = cursor[p];
    ofs   = cur[5:0];
    lvl   = fill[p];
    for (int i = 0; i < LINE; i++) bytes[i] = '0;
    case (it.cmd)
      CMD_SEED: begin
        cursor[p] = it.address;
        fill[p]   = {1'b0, it.address[5:0]};
      end
      CMD_DRAIN: begin
        if (combining && lvl > ofs) begin
          for (int i = 0; i < lvl - ofs; i++) bytes[i] = line_store[p][ofs + i];
          queue_beats(cur, bytes, lvl - ofs);
          cursor[p] = cur + ADDR_W'(lvl - ofs);
        end
      end
      CMD_ROW: begin
        for (int i = 0; i < 8; i++) begin
          bytes[i]     = it.data_low[8*i +: 8];
          bytes[i + 8] = it.data_high[8*i +: 8];
        end
        if (!combining) begin
          queue_beats(cur, bytes, width);
          cursor[p] = cur + ADDR_W'(width);
        end else begin
          for (int i = 0; i < width; i++)
            if (lvl + i < LINE) line_store[p][lvl + i] = bytes[i];
          lvl += width;
          if (lvl >= LINE) begin
            for (int i = 0; i < LINE - ofs; i++) bytes[i] = line_store[p][ofs + i];
            queue_beats(cur, bytes, LINE - ofs);
            cursor[p] = cur + ADDR_W'(LINE - ofs);
            lvl = 0;
          end
          fill[p] = 7'(lvl);
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      size_code  = 3'd3;
      combining  = 1'b1;
      fail_count = 0;
      beats_seen = 0;
      beat_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_ELEM_SIZE) size_code = cfg_data;
        else if (cfg_index == CFG_WC) combining = cfg_data[0];
      end
      if (in_valid && in_ready) predict_beats(in_item);
      if (out_valid && out_ready) begin
        beats_seen++;
        if (beat_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected beat: addr %h data %h be %h last %b", out_item.write_address,
                     out_item.write_data, out_item.byte_enable, out_item.last_beat);
        end else begin
          want = beat_q.pop_front();
          if (want.write_address != out_item.write_address ||
              want.write_data != out_item.write_data ||
              want.byte_enable != out_item.byte_enable ||
              want.last_beat != out_item.last_beat) begin
            fail_count++;
            if (fail_count <= 10)
              $display("beat mismatch: expected addr %h data %h be %h last %b, got %h %h %h %b",
                       want.write_address, want.write_data, want.byte_enable, want.last_beat,
                       out_item.write_address, out_item.write_data, out_item.byte_enable,
                       out_item.last_beat);
          end
        end
      end
    end
    pending = beat_q.size();
  end
endmodule
`default_nettype wire

/* tb/sv/testbench.sv */
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import rsw_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 9;
  localparam int ITEMS_PER_PHASE = 36;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  in_item_t              in_item;
  logic                  out_valid;
  logic                  out_ready;
  out_item_t             out_item;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    pending;
  int                    beats_seen;

  int      send_idle_pct;
  int      recv_stall_pct;
  bit      hold_req;
  int      cycles;
  int      items_sent;
  int      cur_size;
  int      live_parts [$];

  radix_scatter_write_combine dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  rsw_scoreboard u_scoreboard (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending), .beats_seen(beats_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        for (int k = 0; k < 300; k++) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic send_item(input in_item_t it);
    bit taken;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    items_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end while (!taken);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (30) @(posedge clk);
  endtask

  function automatic in_item_t make_item(input logic [1:0] cmd, input int p,
                                         input logic [ADDR_W-1:0] addr,
                                         input logic [63:0] lo, input logic [63:0] hi);
    in_item_t it;
    it.cmd       = cmd;
    it.partition = 8'(p);
    it.address   = addr;
    it.data_low  = lo;
    it.data_high = hi;
    return it;
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr(input bit aligned);
    logic [ADDR_W-1:0] a;
    a = ADDR_W'({$urandom, $urandom});
    if ($urandom_range(9) == 0) a[ADDR_W-1:6] = '1;
    if (aligned) a = a & ~ADDR_W'((1 << cur_size) - 1);
    return a;
  endfunction

  task automatic seed_part(input int p);
    send_item(make_item(CMD_SEED, p, rand_addr($urandom_range(5) != 0), '0, '0));
    live_parts = {live_parts, p};
  endtask

  task automatic send_random();
    int          r;
    int          p;
    logic [63:0] lo;
    logic [63:0] hi;
    r  = $urandom_range(99);
    p  = live_parts[$urandom_range(live_parts.size() - 1)];
    lo = {$urandom, $urandom};
    hi = {$urandom, $urandom};
    if (r < 78) send_item(make_item(CMD_ROW, p, rand_addr(0), lo, hi));
    else if (r < 88) send_item(make_item(CMD_DRAIN, p, rand_addr(0), lo, hi));
    else if (r < 94) seed_part((r & 1) ? p : $urandom_range(255));
    else send_item(make_item(CMD_UNUSED, $urandom_range(255), rand_addr(0), lo, hi));
  endtask

  initial begin
    int          size_codes [PHASES];
    bit          modes [PHASES];
    logic [63:0] pat;
    size_codes = '{3'd0, 3'd4, 3'd2, 3'd7, 3'd4, 3'd1, 3'd3, 3'd0, 3'd4};
    modes      = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_item   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    hold_req       = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    items_sent     = 0;
    cur_size       = 3;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    pat = 64'h0123_4567_89ab_cdef;
    send_item(make_item(CMD_SEED, 0, 48'hffff_ffff_ffe0, '0, '0));
    send_item(make_item(CMD_ROW, 0, '0, '1, '1));
    send_item(make_item(CMD_ROW, 0, '1, '0, '0));
    send_item(make_item(CMD_ROW, 0, '0, pat, ~pat));
    send_item(make_item(CMD_ROW, 0, '0, ~pat, pat));
    send_item(make_item(CMD_DRAIN, 0, '0, '0, '0));
    send_item(make_item(CMD_SEED, 255, 48'h0000_0000_0013, '1, '1));
    send_item(make_item(CMD_ROW, 255, '0, pat, '0));
    send_item(make_item(CMD_DRAIN, 255, '0, '0, '0));
    send_item(make_item(CMD_UNUSED, 255, '1, '1, '1));
    send_item(make_item(CMD_ROW, 0, '0, '1, '0));
    send_item(make_item(CMD_DRAIN, 0, '0, '0, '0));
    send_item(make_item(CMD_SEED, 128, 48'h8000_0000_0000, '0, '0));
    for (int i = 0; i < 8; i++)
      send_item(make_item(CMD_ROW, 128, '0, {$urandom, $urandom}, '0));
    wait_drained();

    for (int ph = 0; ph < PHASES; ph++) begin
      write_reg(CFG_ELEM_SIZE, CFG_DATA_W'(size_codes[ph]));
      write_reg(CFG_WC, CFG_DATA_W'(modes[ph]));
      cur_size       = (size_codes[ph] > 4) ? 4 : size_codes[ph];
      send_idle_pct  = (ph % 4 == 1 || ph % 4 == 3) ? ((ph % 4 == 1) ? 59 : 23) : 0;
      recv_stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? ((ph % 4 == 2) ? 59 : 23) : 0;
      live_parts.delete();
      for (int k = 0; k < 1 + cur_size / 2 + 1; k++) seed_part($urandom_range(255));
      if (ph == 4) begin
        send_idle_pct = 0;
        hold_req      = 1'b1;
      end
      for (int k = 0; k < ITEMS_PER_PHASE; k++) send_random();
      wait_drained();
    end

    $display("%0d items sent over %0d settings, %0d write beats checked", items_sent,
             PHASES + 1, beats_seen);
    $display("covered seed, row, drain and ignored commands in direct and staged modes");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire
